>>> rtl/tlv_pkg.sv
// ----------------------------------------------------------------------------
// tlv_pkg
// shared types and constants of the tlv stream walker
// ----------------------------------------------------------------------------
package tlv_pkg;

    // bytes skipped at the head of every packet
    localparam int TLV_PREFIX_BYTES = 5;

    // default depth of the queue between parser and output stage
    localparam int TLV_QUEUE_DEPTH = 4;

    // reset value of max_tlvs
    localparam logic [15:0] TLV_MAX_TLVS_RESET = 16'hFFFF;

    // result kinds
    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_CONTENT = 2'd1;
    localparam logic [1:0] KIND_SUMMARY = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] rec_type;
        logic [15:0] tlv_length;
        logic [15:0] content_offset;
        logic [15:0] tlv_index;
        logic [7:0]  content_byte;
        logic        end_of_record;
        logic [15:0] record_count;
        logic        malformed;
    } tlv_result_t;

    // one queue entry: results caused by one input byte
    typedef struct packed {
        logic        rec_valid;
        tlv_result_t rec;
        logic        sum_valid;
        logic [15:0] sum_count;
        logic        sum_malformed;
    } tlv_entry_t;

endpackage

>>> rtl/tlv_if.sv
// ----------------------------------------------------------------------------
// tlv_if
// channel interfaces of the tlv stream walker: bytes in, results out, config
// ----------------------------------------------------------------------------
interface tlv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface tlv_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] rec_type;
    logic [15:0] tlv_length;
    logic [15:0] content_offset;
    logic [15:0] tlv_index;
    logic [7:0]  content_byte;
    logic        end_of_record;
    logic [15:0] record_count;
    logic        malformed;
    logic        last_result;

    modport source (
        output valid, output kind, output rec_type, output tlv_length,
        output content_offset, output tlv_index, output content_byte,
        output end_of_record, output record_count, output malformed,
        output last_result, input ready
    );
    modport sink (
        input valid, input kind, input rec_type, input tlv_length,
        input content_offset, input tlv_index, input content_byte,
        input end_of_record, input record_count, input malformed,
        input last_result, output ready
    );
endinterface

interface tlv_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] max_tlvs;

    modport source (output valid, output max_tlvs, input ready);
    modport sink (input valid, input max_tlvs, output ready);
endinterface

>>> rtl/tlv_stream_walker.sv
// ----------------------------------------------------------------------------
// tlv_stream_walker
// walks the type-length-value records of a byte stream, one packet at a time
// ----------------------------------------------------------------------------
// Takes one packet byte per clock cycle on the bytes channel, with last_byte
// set on the final byte. The first TLV_PREFIX_BYTES bytes of each packet are
// skipped; after them each record is a big-endian 16-bit type, a big-endian
// 16-bit length and that many content bytes. For every completed header a
// kind 0 result gives type, length, record index and content offset; every
// content byte comes out as a kind 1 result; the last byte adds a kind 2
// summary with the record count and a malformed flag (packet ended inside a
// header). Records at or past max_tlvs are counted but not reported.
// Timing: a byte transfer puts its results into a QUEUE_DEPTH-entry queue in
// the same edge; the first result is offered once the output stage loads the
// entry from the queue head. Input is taken every cycle while the queue has
// room; the output stage sends one result per cycle while results.ready is
// high, so a last byte that also closes a header or carries content gives
// two results, and the queue absorbs that. bytes.ready drops only when the
// queue is full. max_tlvs (kept across packets, reset to 65535) must be
// written through always-ready cfg only while the block is idle (not enforced).
// ----------------------------------------------------------------------------
module tlv_stream_walker #(
    parameter int QUEUE_DEPTH = tlv_pkg::TLV_QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    tlv_in_if.sink     bytes,
    tlv_cfg_if.sink    cfg,
    tlv_out_if.source  results
);
    import tlv_pkg::*;

    // parser to queue
    logic       q_push;
    tlv_entry_t q_push_data;
    logic       q_full;

    // queue to output stage
    logic       q_pop_valid;
    logic       q_pop_ready;
    tlv_entry_t q_pop_data;

    // front: classifies each byte and builds its results
    tlv_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .bytes  (bytes),
        .cfg    (cfg),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_push_data)
    );

    // decoupling queue, lets output stalls not stop the byte stream at once
    tlv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop_valid (q_pop_valid),
        .pop_ready (q_pop_ready),
        .pop_data  (q_pop_data)
    );

    // back: sends the results of each entry in order, one per transfer
    tlv_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_pop_valid),
        .q_data  (q_pop_data),
        .q_ready (q_pop_ready),
        .results (results)
    );

endmodule

>>> rtl/tlv_front.sv
// ----------------------------------------------------------------------------
// tlv_front
// byte parser: prefix skip, header collection, content walk, packet summary
// ----------------------------------------------------------------------------
module tlv_front (
    input  logic                clk,
    input  logic                rst_n,
    tlv_in_if.sink              bytes,
    tlv_cfg_if.sink             cfg,
    input  logic                q_full,
    output logic                q_push,
    output tlv_pkg::tlv_entry_t q_data
);
    import tlv_pkg::*;

    localparam logic [1:0] PH_PREFIX  = 2'd0;
    localparam logic [1:0] PH_HEADER  = 2'd1;
    localparam logic [1:0] PH_CONTENT = 2'd2;
    localparam logic [1:0] PH_START   = (TLV_PREFIX_BYTES == 0) ? PH_HEADER : PH_PREFIX;

    logic [15:0] max_tlvs_reg;
    logic [1:0]  phase_reg, phase_next;
    logic [15:0] pos_reg, pos_next;
    logic [1:0]  hdr_seen_reg, hdr_seen_next;
    logic [15:0] cur_type_reg, cur_type_next;
    logic [15:0] remaining_reg, remaining_next;
    logic [15:0] records_reg, records_next;
    logic        reported_reg, reported_next;
    logic        xfer;
    tlv_entry_t  entry;

    assign bytes.ready = !q_full;
    assign cfg.ready   = 1'b1;
    assign xfer        = bytes.valid && bytes.ready;

    always_comb
    begin
        phase_next     = phase_reg;
        pos_next       = (pos_reg != 16'hFFFF) ? pos_reg + 16'd1 : pos_reg;
        hdr_seen_next  = hdr_seen_reg;
        cur_type_next  = cur_type_reg;
        remaining_next = remaining_reg;
        records_next   = records_reg;
        reported_next  = reported_reg;
        entry          = '0;

        case (phase_reg)
            PH_PREFIX:
            begin
                if (pos_next >= 16'(TLV_PREFIX_BYTES))
                    phase_next = PH_HEADER;
            end
            PH_HEADER:
            begin
                if (!hdr_seen_reg[1])
                    cur_type_next = {cur_type_reg[7:0], bytes.data_byte};
                else
                    remaining_next = {remaining_reg[7:0], bytes.data_byte};
                hdr_seen_next = hdr_seen_reg + 2'd1;
                if (hdr_seen_reg == 2'd3)
                begin
                    reported_next = records_reg < max_tlvs_reg;
                    if (reported_next)
                    begin
                        entry.rec_valid          = 1'b1;
                        entry.rec.kind           = KIND_HEADER;
                        entry.rec.rec_type       = cur_type_reg;
                        entry.rec.tlv_length     = remaining_next;
                        // offset of the next byte, saturated like the position
                        entry.rec.content_offset = pos_next;
                        entry.rec.tlv_index      = records_reg;
                    end
                    if (records_reg != 16'hFFFF)
                        records_next = records_reg + 16'd1;
                    phase_next = (remaining_next == 16'd0) ? PH_HEADER : PH_CONTENT;
                end
            end
            PH_CONTENT:
            begin
                remaining_next = remaining_reg - 16'd1;
                if (reported_reg)
                begin
                    entry.rec_valid         = 1'b1;
                    entry.rec.kind          = KIND_CONTENT;
                    entry.rec.tlv_index     = records_reg - 16'd1;
                    entry.rec.content_byte  = bytes.data_byte;
                    entry.rec.end_of_record = remaining_next == 16'd0;
                end
                if (remaining_next == 16'd0)
                begin
                    phase_next    = PH_HEADER;
                    cur_type_next = 16'd0;
                end
            end
            default:
            begin
                phase_next = PH_HEADER;
            end
        endcase

        if (bytes.last_byte)
        begin
            entry.sum_valid     = 1'b1;
            entry.sum_count     = records_next;
            entry.sum_malformed = (phase_next == PH_HEADER) && (hdr_seen_next != 2'd0);
            phase_next     = PH_START;
            pos_next       = 16'd0;
            hdr_seen_next  = 2'd0;
            cur_type_next  = 16'd0;
            remaining_next = 16'd0;
            records_next   = 16'd0;
            reported_next  = 1'b0;
        end
    end

    assign q_push = xfer && (entry.rec_valid || entry.sum_valid);
    assign q_data = entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_tlvs_reg  <= TLV_MAX_TLVS_RESET;
            phase_reg     <= PH_START;
            pos_reg       <= 16'd0;
            hdr_seen_reg  <= 2'd0;
            cur_type_reg  <= 16'd0;
            remaining_reg <= 16'd0;
            records_reg   <= 16'd0;
            reported_reg  <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
                max_tlvs_reg <= cfg.max_tlvs;
            if (xfer)
            begin
                phase_reg     <= phase_next;
                pos_reg       <= pos_next;
                hdr_seen_reg  <= hdr_seen_next;
                cur_type_reg  <= cur_type_next;
                remaining_reg <= remaining_next;
                records_reg   <= records_next;
                reported_reg  <= reported_next;
            end
        end
    end

    // header bytes are only counted while collecting a header
    a_hdr_only_in_header: assert property (@(posedge clk) disable iff (!rst_n)
        (hdr_seen_reg != 2'd0) |-> (phase_reg == PH_HEADER))
        else $error("header byte count set outside header phase");

    // content phase always has bytes left to walk
    a_content_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_CONTENT) |-> (remaining_reg != 16'd0))
        else $error("content phase with nothing remaining");

    // a last byte always leaves a summary in the queue
    a_last_pushes: assert property (@(posedge clk) disable iff (!rst_n)
        (xfer && bytes.last_byte) |-> (q_push && q_data.sum_valid))
        else $error("last byte without summary");

endmodule

>>> rtl/tlv_queue.sv
// ----------------------------------------------------------------------------
// tlv_queue
// short fifo of per-byte result entries between parser and output stage
// ----------------------------------------------------------------------------
module tlv_queue #(
    parameter int DEPTH = tlv_pkg::TLV_QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  tlv_pkg::tlv_entry_t push_data,
    output logic                full,
    output logic                pop_valid,
    input  logic                pop_ready,
    output tlv_pkg::tlv_entry_t pop_data
);
    import tlv_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    tlv_entry_t       store [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = count_reg == CNT_FULL;
    assign pop_valid = count_reg != '0;
    assign pop_data  = store[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            store[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            count_reg <= count_next;
        end
    end

    // the parser never offers an entry while the queue is full
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("push into full queue");

    // every stored entry carries at least one result
    a_entry_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop_valid |-> (pop_data.rec_valid || pop_data.sum_valid))
        else $error("empty entry at queue head");

endmodule

>>> rtl/tlv_back.sv
// ----------------------------------------------------------------------------
// tlv_back
// output stage: holds one entry and sends its results one per transfer
// ----------------------------------------------------------------------------
module tlv_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  tlv_pkg::tlv_entry_t q_data,
    output logic                q_ready,
    tlv_out_if.source           results
);
    import tlv_pkg::*;

    logic        entry_valid_reg;
    tlv_entry_t  entry_reg;
    logic        rec_done_reg;
    logic        show_rec;
    logic        xfer;
    logic        finish;
    tlv_result_t shown;

    assign show_rec = entry_reg.rec_valid && !rec_done_reg;
    assign xfer     = entry_valid_reg && results.ready;
    assign finish   = xfer && !(show_rec && entry_reg.sum_valid);
    assign q_ready  = !entry_valid_reg || finish;

    always_comb
    begin
        if (show_rec)
        begin
            shown = entry_reg.rec;
        end
        else
        begin
            shown              = '0;
            shown.kind         = KIND_SUMMARY;
            shown.record_count = entry_reg.sum_count;
            shown.malformed    = entry_reg.sum_malformed;
        end
    end

    assign results.valid          = entry_valid_reg;
    assign results.kind           = shown.kind;
    assign results.rec_type       = shown.rec_type;
    assign results.tlv_length     = shown.tlv_length;
    assign results.content_offset = shown.content_offset;
    assign results.tlv_index      = shown.tlv_index;
    assign results.content_byte   = shown.content_byte;
    assign results.end_of_record  = shown.end_of_record;
    assign results.record_count   = shown.record_count;
    assign results.malformed      = shown.malformed;
    assign results.last_result    = show_rec ? !entry_reg.sum_valid : 1'b1;

    always_ff @(posedge clk)
    begin
        if (q_ready && q_valid)
            entry_reg <= q_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= 1'b0;
            rec_done_reg    <= 1'b0;
        end
        else if (q_ready)
        begin
            entry_valid_reg <= q_valid;
            rec_done_reg    <= 1'b0;
        end
        else if (xfer)
        begin
            rec_done_reg <= 1'b1;
        end
    end

    // after the record result of a two-result entry the summary follows
    a_summary_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (xfer && show_rec && entry_reg.sum_valid) |=>
            (entry_valid_reg && rec_done_reg && !show_rec))
        else $error("summary lost after record result");

    // the record part is marked sent only on entries that also hold a summary
    a_done_needs_summary: assert property (@(posedge clk) disable iff (!rst_n)
        rec_done_reg |-> (entry_valid_reg && entry_reg.sum_valid))
        else $error("record marked sent on single-result entry");

endmodule
